FILE: hdl/qlst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qlst_pkg
// Shared types, byte constants and error codes of the string tokenizer.
// ----------------------------------------------------------------------------
package qlst_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int DIGIT_BITS      = 4;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_START = 3'd1;
	localparam logic [2:0] ERR_NO_DIGITS = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
	localparam logic [2:0] ERR_BAD_TERM  = 3'd4;

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_QUOTE  = 4'd1,
		PH_QESC   = 4'd2,
		PH_SKIP   = 4'd3,
		PH_LEN    = 4'd4,
		PH_TBRACE = 4'd5,
		PH_TCR    = 4'd6,
		PH_TLF    = 4'd7,
		PH_LIT    = 4'd8,
		PH_DRAIN  = 4'd9
	} phase_t;

	// first error wins
	function automatic logic [2:0] record_err(input logic [2:0] cur, input logic [2:0] code);
		return (cur == ERR_NONE) ? code : cur;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/qlst_len_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qlst_len_acc
// Decimal length accumulator: next = cur * 10 + digit, with range check.
// ----------------------------------------------------------------------------
module qlst_len_acc
	import qlst_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic [LENGTH_BITS-1:0] cur,
	input  wire logic [DIGIT_BITS-1:0]  digit,
	output logic      [LENGTH_BITS-1:0] next,
	output logic                        overflow
);

	localparam int WIDE = LENGTH_BITS + DIGIT_BITS;

	logic [WIDE-1:0] cur_w;
	logic [WIDE-1:0] sum_w;

	// x*10 as x*8 + x*2
	assign cur_w    = {{DIGIT_BITS{1'b0}}, cur};
	assign sum_w    = (cur_w << 3) + (cur_w << 1) + {{LENGTH_BITS{1'b0}}, digit};
	assign overflow = |sum_w[WIDE-1:LENGTH_BITS];
	assign next     = sum_w[LENGTH_BITS-1:0];

endmodule
`default_nettype wire

FILE: hdl/quoted_literal_string_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_literal_string_tokenizer
// Splits argument text into quoted and {N+}CRLF literal string tokens.
// ----------------------------------------------------------------------------
// One byte per request, one request per cycle: the parse state updates in the
// cycle a byte is taken, and the result sits in an output register, so a new
// byte is taken while a result waits as long as the sink takes it in the same
// cycle. A byte's result is valid in the cycle after it is taken. Bytes that give
// no result (skipped spaces, opening quotes and braces, length digits,
// drained bytes after a bad start) produce no output request.
module quoted_literal_string_tokenizer
	import qlst_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
	input  wire logic        s_tlast,   // arg_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // [7:0] content_byte, [8] content_valid,
	                                    // [9] token_done, [12:10] error_code, [15:13] 0
	output logic             m_tlast    // arg_done
);

	phase_t                 phase_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic                   digits_q;
	logic                   ovf_q;
	logic [2:0]             err_q;

	logic                   out_valid_q;
	logic [15:0]            out_data_q;
	logic                   out_last_q;

	phase_t                 phase_d;
	logic [LENGTH_BITS-1:0] len_d;
	logic                   digits_d;
	logic                   ovf_d;
	logic [2:0]             err_d;
	logic                   cv;
	logic                   td;
	logic                   emit;

	logic [LENGTH_BITS-1:0] acc_next;
	logic                   acc_ovf;
	logic                   accept;
	logic [7:0]             b;

	assign b        = s_tdata;
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	qlst_len_acc #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_len_acc (
		.cur     (len_q),
		.digit   (DIGIT_BITS'(b - CH_ZERO)),
		.next    (acc_next),
		.overflow(acc_ovf)
	);

	always_comb begin
		phase_t p;
		p        = phase_q;
		len_d    = len_q;
		digits_d = digits_q;
		ovf_d    = ovf_q;
		err_d    = err_q;
		cv       = 1'b0;
		td       = 1'b0;
		if (p == PH_SKIP && b != CH_SPACE) begin
			p = PH_START;
		end
		phase_d = p;
		case (p)
			PH_START: begin
				if (b == CH_DQUOTE) begin
					phase_d = PH_QUOTE;
				end else if (b == CH_LBRACE) begin
					phase_d  = PH_LEN;
					len_d    = '0;
					digits_d = 1'b0;
					ovf_d    = 1'b0;
				end else begin
					err_d   = record_err(err_d, ERR_BAD_START);
					td      = 1'b1;
					phase_d = PH_DRAIN;
				end
			end
			PH_QUOTE: begin
				if (b == CH_BSLASH) begin
					phase_d = PH_QESC;
				end else if (b == CH_DQUOTE) begin
					td      = 1'b1;
					phase_d = PH_SKIP;
				end else begin
					cv = 1'b1;
				end
			end
			PH_QESC: begin
				cv      = 1'b1;
				phase_d = PH_QUOTE;
			end
			PH_SKIP: begin
			end
			PH_LEN: begin
				if (b inside {[CH_ZERO:CH_NINE]}) begin
					digits_d = 1'b1;
					if (!ovf_q) begin
						if (acc_ovf) begin
							ovf_d = 1'b1;
							len_d = '0;
							err_d = record_err(err_d, ERR_OVERFLOW);
						end else begin
							len_d = acc_next;
						end
					end
				end else begin
					if (!digits_q) err_d = record_err(err_d, ERR_NO_DIGITS);
					if (b != CH_PLUS) err_d = record_err(err_d, ERR_BAD_TERM);
					phase_d = PH_TBRACE;
				end
			end
			PH_TBRACE: begin
				if (b != CH_RBRACE) err_d = record_err(err_d, ERR_BAD_TERM);
				phase_d = PH_TCR;
			end
			PH_TCR: begin
				if (b != CH_CR) err_d = record_err(err_d, ERR_BAD_TERM);
				phase_d = PH_TLF;
			end
			PH_TLF: begin
				if (b != CH_LF) err_d = record_err(err_d, ERR_BAD_TERM);
				if (len_q == '0) begin
					td      = 1'b1;
					phase_d = PH_START;
				end else begin
					phase_d = PH_LIT;
				end
			end
			PH_LIT: begin
				cv    = 1'b1;
				len_d = len_q - 1'b1;
				if (len_d == '0) begin
					td      = 1'b1;
					phase_d = PH_START;
				end
			end
			default: begin
				phase_d = PH_DRAIN;
			end
		endcase
		if (s_tlast) begin
			case (phase_d)
				PH_QUOTE, PH_QESC, PH_LIT: begin
					td = 1'b1;
				end
				PH_LEN: begin
					if (!digits_d) err_d = record_err(err_d, ERR_NO_DIGITS);
					err_d = record_err(err_d, ERR_BAD_TERM);
					td    = 1'b1;
				end
				PH_TBRACE, PH_TCR, PH_TLF: begin
					err_d = record_err(err_d, ERR_BAD_TERM);
					td    = 1'b1;
				end
				default: begin
				end
			endcase
		end
		emit = cv || td || s_tlast || (err_q == ERR_NONE && err_d != ERR_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			len_q       <= '0;
			digits_q    <= 1'b0;
			ovf_q       <= 1'b0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= emit;
				if (s_tlast) begin
					phase_q  <= PH_START;
					len_q    <= '0;
					digits_q <= 1'b0;
					ovf_q    <= 1'b0;
					err_q    <= ERR_NONE;
				end else begin
					phase_q  <= phase_d;
					len_q    <= len_d;
					digits_q <= digits_d;
					ovf_q    <= ovf_d;
					err_q    <= err_d;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_data_q <= {3'b000, err_d, td, cv, (cv ? b : 8'h00)};
			out_last_q <= s_tlast;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_arg_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (phase_q == PH_START && err_q == ERR_NONE && len_q == '0))
		else $error("state not cleared after argument end");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE && !(accept && s_tlast)) |=> (err_q == $past(err_q)))
		else $error("recorded error changed inside argument");

	a_lit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LIT) |-> (len_q != '0))
		else $error("literal phase with zero bytes left");

	a_content_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == 8'h00))
		else $error("content byte set without content_valid");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[12:10] <= ERR_BAD_TERM))
		else $error("error code out of range");
`endif

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the quoted and literal string tokenizer.
// ----------------------------------------------------------------------------
// A short table of hand-picked argument bytes runs first: quoted strings with
// escapes, skipped spaces, a small literal, a bad start, a length with no
// digits, a bad terminator and an escape as the final byte. Random arguments
// follow. Each request taken by the block is run through a local tokenizer, and
// its results, or for table rows the results in the table, are compared in order
// with the output requests. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import qlst_pkg::*;

	localparam int PLAN_LEN     = 26;
	localparam int RANDOM_ITEMS = 800;
	localparam int QUIET_LIMIT  = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       done;
		logic [2:0] err;
		logic       arg_end;
	} tok_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       typed;
		tok_res_t   res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	logic        calm;
	logic        row_typed;
	tok_res_t    row_result;
	int          fails = 0;
	int          quiet = 0;

	logic [7:0]  arg_bytes [$];
	tok_res_t    token_results_due [$];

	// local tokenizer state
	phase_t      phase      = PH_START;
	logic [31:0] len_acc    = '0;
	logic        have_digit = 1'b0;
	logic        len_big    = 1'b0;
	logic [2:0]  err_kept   = ERR_NONE;

	row_t plan [PLAN_LEN] = '{
		'{CH_DQUOTE, 1'b0, 1'b0, '0},
		'{8'hFF,     1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, ERR_NONE, 1'b0}},
		'{CH_BSLASH, 1'b0, 1'b0, '0},
		'{CH_DQUOTE, 1'b0, 1'b1, '{CH_DQUOTE, 1'b1, 1'b0, ERR_NONE, 1'b0}},
		'{CH_DQUOTE, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, ERR_NONE, 1'b0}},
		'{CH_SPACE,  1'b0, 1'b0, '0},
		'{CH_LBRACE, 1'b0, 1'b0, '0},
		'{8'h31,     1'b0, 1'b0, '0},
		'{CH_PLUS,   1'b0, 1'b0, '0},
		'{CH_RBRACE, 1'b0, 1'b0, '0},
		'{CH_CR,     1'b0, 1'b0, '0},
		'{CH_LF,     1'b0, 1'b0, '0},
		'{8'h00,     1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_NONE, 1'b1}},
		'{8'h41,     1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, ERR_BAD_START, 1'b0}},
		'{CH_LBRACE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_BAD_START, 1'b1}},
		'{CH_LBRACE, 1'b0, 1'b0, '0},
		'{CH_PLUS,   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_NO_DIGITS, 1'b0}},
		'{CH_RBRACE, 1'b0, 1'b0, '0},
		'{CH_CR,     1'b0, 1'b0, '0},
		'{CH_LF,     1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ERR_NO_DIGITS, 1'b1}},
		'{CH_LBRACE, 1'b0, 1'b0, '0},
		'{CH_ZERO,   1'b0, 1'b0, '0},
		'{8'h2D,     1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_BAD_TERM, 1'b0}},
		'{CH_RBRACE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ERR_BAD_TERM, 1'b1}},
		'{CH_DQUOTE, 1'b0, 1'b0, '0},
		'{CH_BSLASH, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ERR_NONE, 1'b1}}
	};

	quoted_literal_string_tokenizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_error(input logic [2:0] code, inout logic fresh);
		if (err_kept == ERR_NONE) begin
			err_kept = code;
			fresh = 1'b1;
		end
	endfunction

	// returns 1 when the byte gives a result
	function automatic logic tokenize_byte(input logic [7:0] b, input logic l,
			output tok_res_t r);
		logic       cv;
		logic       td;
		logic       fresh;
		logic [35:0] grown;
		cv = 1'b0;
		td = 1'b0;
		fresh = 1'b0;
		if (phase == PH_SKIP && b != CH_SPACE)
			phase = PH_START;
		case (phase)
			PH_START: begin
				if (b == CH_DQUOTE) begin
					phase = PH_QUOTE;
				end else if (b == CH_LBRACE) begin
					phase = PH_LEN;
					len_acc = '0;
					have_digit = 1'b0;
					len_big = 1'b0;
				end else begin
					note_error(ERR_BAD_START, fresh);
					td = 1'b1;
					phase = PH_DRAIN;
				end
			end
			PH_QUOTE: begin
				if (b == CH_BSLASH) begin
					phase = PH_QESC;
				end else if (b == CH_DQUOTE) begin
					td = 1'b1;
					phase = PH_SKIP;
				end else begin
					cv = 1'b1;
				end
			end
			PH_QESC: begin
				cv = 1'b1;
				phase = PH_QUOTE;
			end
			PH_SKIP: ;
			PH_LEN: begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					have_digit = 1'b1;
					if (!len_big) begin
						grown = {4'b0, len_acc} * 36'd10 + {28'b0, b - CH_ZERO};
						if (grown > 36'hFFFF_FFFF) begin
							len_big = 1'b1;
							len_acc = '0;
							note_error(ERR_OVERFLOW, fresh);
						end else begin
							len_acc = grown[31:0];
						end
					end
				end else begin
					if (!have_digit)
						note_error(ERR_NO_DIGITS, fresh);
					if (b != CH_PLUS)
						note_error(ERR_BAD_TERM, fresh);
					phase = PH_TBRACE;
				end
			end
			PH_TBRACE: begin
				if (b != CH_RBRACE)
					note_error(ERR_BAD_TERM, fresh);
				phase = PH_TCR;
			end
			PH_TCR: begin
				if (b != CH_CR)
					note_error(ERR_BAD_TERM, fresh);
				phase = PH_TLF;
			end
			PH_TLF: begin
				if (b != CH_LF)
					note_error(ERR_BAD_TERM, fresh);
				if (len_acc == 0) begin
					td = 1'b1;
					phase = PH_START;
				end else begin
					phase = PH_LIT;
				end
			end
			PH_LIT: begin
				cv = 1'b1;
				len_acc = len_acc - 1;
				if (len_acc == 0) begin
					td = 1'b1;
					phase = PH_START;
				end
			end
			default: phase = PH_DRAIN;
		endcase
		if (l) begin
			case (phase)
				PH_QUOTE, PH_QESC, PH_LIT: td = 1'b1;
				PH_LEN: begin
					if (!have_digit)
						note_error(ERR_NO_DIGITS, fresh);
					note_error(ERR_BAD_TERM, fresh);
					td = 1'b1;
				end
				PH_TBRACE, PH_TCR, PH_TLF: begin
					note_error(ERR_BAD_TERM, fresh);
					td = 1'b1;
				end
				default: ;
			endcase
		end
		r = '{cv ? b : 8'h00, cv, td, err_kept, l};
		if (l) begin
			phase = PH_START;
			len_acc = '0;
			have_digit = 1'b0;
			len_big = 1'b0;
			err_kept = ERR_NONE;
		end
		return cv || td || l || fresh;
	endfunction

	// one random argument: mostly well-formed tokens, some broken, a few cut short
	task automatic build_argument();
		logic [7:0]  term [4] = '{CH_PLUS, CH_RBRACE, CH_CR, CH_LF};
		logic [7:0]  b;
		logic [63:0] big;
		string       digits;
		int          ntok;
		int          pick;
		int          n;
		int          keep;
		arg_bytes.delete();
		ntok = $urandom_range(1, 4);
		for (int t = 0; t < ntok; t++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				arg_bytes.push_back(CH_DQUOTE);
				n = $urandom_range(0, 8);
				for (int i = 0; i < n; i++) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_DQUOTE || b == CH_BSLASH || $urandom_range(0, 9) == 0)
						arg_bytes.push_back(CH_BSLASH);
					arg_bytes.push_back(b);
				end
				arg_bytes.push_back(CH_DQUOTE);
				repeat ($urandom_range(0, 2))
					arg_bytes.push_back(CH_SPACE);
			end else if (pick < 88) begin
				arg_bytes.push_back(CH_LBRACE);
				pick = $urandom_range(0, 99);
				n = 0;
				if (pick < 5) begin
					digits = "";
				end else if (pick < 12) begin
					big = 64'd4294967296 + 64'($urandom_range(0, 5000000));
					digits = $sformatf("%0d", big);
				end else begin
					n = $urandom_range(0, 6);
					digits = $sformatf("%0d", n);
					if ($urandom_range(0, 4) == 0)
						digits = {"0", digits};
				end
				for (int i = 0; i < digits.len(); i++)
					arg_bytes.push_back(digits[i]);
				for (int i = 0; i < 4; i++) begin
					b = term[i];
					if ($urandom_range(0, 19) == 0)
						b = 8'($urandom_range(0, 255));
					arg_bytes.push_back(b);
				end
				repeat (n)
					arg_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4))
					arg_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			keep = $urandom_range(1, arg_bytes.size());
			while (arg_bytes.size() > keep)
				void'(arg_bytes.pop_back());
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
			input tok_res_t res);
		while (!calm && $urandom_range(0, 99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid   <= 1'b1;
		s_tdata    <= b;
		s_tlast    <= l;
		row_typed  <= typed;
		row_result <= res;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= calm || $urandom_range(0, 99) >= 18;
	end

	always @(posedge clk) begin
		tok_res_t got;
		tok_res_t want;
		tok_res_t calc;
		logic     gives;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[12:10], m_tlast};
				if (token_results_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: data=%h valid=%b done=%b err=%0d arg=%b",
							got.data, got.valid, got.done, got.err, got.arg_end);
				end else begin
					want = token_results_due.pop_front();
					if (got.data !== want.data || got.valid !== want.valid ||
							got.done !== want.done || got.err !== want.err ||
							got.arg_end !== want.arg_end) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: got %s, want %s",
								$sformatf("data=%h valid=%b done=%b err=%0d arg=%b",
									got.data, got.valid, got.done, got.err,
									got.arg_end),
								$sformatf("data=%h valid=%b done=%b err=%0d arg=%b",
									want.data, want.valid, want.done, want.err,
									want.arg_end));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				gives = tokenize_byte(s_tdata, s_tlast, calc);
				if (row_typed)
					token_results_due.push_back(row_result);
				else if (gives)
					token_results_due.push_back(calc);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		int sent;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		arst_n     = 1'b0;
		calm       = 1'b0;
		row_typed  = 1'b0;
		row_result = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < PLAN_LEN; i++)
			send_byte(plan[i].b, plan[i].l, plan[i].typed, plan[i].res);
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			build_argument();
			calm <= (sent >= 300 && sent < 450);
			for (int i = 0; i < arg_bytes.size(); i++) begin
				send_byte(arg_bytes[i], i == arg_bytes.size() - 1, 1'b0, '0);
				sent++;
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (token_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
